FILE: hw/rtl/rv32i_dec_pkg.sv
`default_nettype none

package rv32i_dec_pkg;

    typedef logic [31:0]        t_word;
    typedef logic signed [31:0] t_imm;
    typedef logic [6:0]         t_opcode;
    typedef logic [4:0]         t_reg;
    typedef logic [2:0]         t_funct3;
    typedef logic [6:0]         t_funct7;
    typedef logic [2:0]         t_fmt;
    typedef logic [4:0]         t_kind;

    localparam t_opcode OP_ZERO   = 7'h00;
    localparam t_opcode OP_LOAD   = 7'h03;
    localparam t_opcode OP_IMM    = 7'h13;
    localparam t_opcode OP_AUIPC  = 7'h17;
    localparam t_opcode OP_STORE  = 7'h23;
    localparam t_opcode OP_REG    = 7'h33;
    localparam t_opcode OP_LUI    = 7'h37;
    localparam t_opcode OP_BRANCH = 7'h63;
    localparam t_opcode OP_JALR   = 7'h67;
    localparam t_opcode OP_JAL    = 7'h6F;
    localparam t_opcode OP_SYSTEM = 7'h73;

    localparam t_funct7 F7_BASE = 7'h00;
    localparam t_funct7 F7_ALT  = 7'h20;

    localparam t_funct3 F3_ADD  = 3'd0;
    localparam t_funct3 F3_SLL  = 3'd1;
    localparam t_funct3 F3_SLT  = 3'd2;
    localparam t_funct3 F3_SLTU = 3'd3;
    localparam t_funct3 F3_XOR  = 3'd4;
    localparam t_funct3 F3_SR   = 3'd5;
    localparam t_funct3 F3_OR   = 3'd6;
    localparam t_funct3 F3_AND  = 3'd7;
    localparam t_funct3 F3_LB   = 3'd0;
    localparam t_funct3 F3_LW   = 3'd2;
    localparam t_funct3 F3_LBU  = 3'd4;
    localparam t_funct3 F3_SB   = 3'd0;
    localparam t_funct3 F3_SW   = 3'd2;
    localparam t_funct3 F3_BEQ  = 3'd0;
    localparam t_funct3 F3_BNE  = 3'd1;
    localparam t_funct3 F3_BLT  = 3'd4;
    localparam t_funct3 F3_BGE  = 3'd5;
    localparam t_funct3 F3_BLTU = 3'd6;
    localparam t_funct3 F3_BGEU = 3'd7;

    localparam t_fmt FMT_R       = 3'd0;
    localparam t_fmt FMT_I       = 3'd1;
    localparam t_fmt FMT_S       = 3'd2;
    localparam t_fmt FMT_B       = 3'd3;
    localparam t_fmt FMT_U       = 3'd4;
    localparam t_fmt FMT_J       = 3'd5;
    localparam t_fmt FMT_NOP     = 3'd6;
    localparam t_fmt FMT_UNKNOWN = 3'd7;

    localparam t_kind K_ADD   = 5'd0;
    localparam t_kind K_SUB   = 5'd1;
    localparam t_kind K_SLT   = 5'd2;
    localparam t_kind K_SLTU  = 5'd3;
    localparam t_kind K_XOR   = 5'd4;
    localparam t_kind K_OR    = 5'd5;
    localparam t_kind K_AND   = 5'd6;
    localparam t_kind K_LB    = 5'd7;
    localparam t_kind K_LW    = 5'd8;
    localparam t_kind K_LBU   = 5'd9;
    localparam t_kind K_ADDI  = 5'd10;
    localparam t_kind K_SLLI  = 5'd11;
    localparam t_kind K_SRLI  = 5'd12;
    localparam t_kind K_SRAI  = 5'd13;
    localparam t_kind K_ORI   = 5'd14;
    localparam t_kind K_ANDI  = 5'd15;
    localparam t_kind K_SB    = 5'd16;
    localparam t_kind K_SW    = 5'd17;
    localparam t_kind K_BEQ   = 5'd18;
    localparam t_kind K_BNE   = 5'd19;
    localparam t_kind K_BLT   = 5'd20;
    localparam t_kind K_BGE   = 5'd21;
    localparam t_kind K_BLTU  = 5'd22;
    localparam t_kind K_BGEU  = 5'd23;
    localparam t_kind K_LUI   = 5'd24;
    localparam t_kind K_JAL   = 5'd25;
    localparam t_kind K_AUIPC = 5'd26;
    localparam t_kind K_JALR  = 5'd27;
    localparam t_kind K_ECALL = 5'd28;

endpackage

`default_nettype wire

FILE: hw/rtl/rv32i_dec_if.sv
`default_nettype none

interface rv32i_dec_in_if;
    logic                  valid;
    logic                  ready;
    rv32i_dec_pkg::t_word  instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rv32i_dec_out_if;
    logic                    valid;
    logic                    ready;
    rv32i_dec_pkg::t_opcode  major_opcode;
    rv32i_dec_pkg::t_reg     dest_reg;
    rv32i_dec_pkg::t_reg     src1_reg;
    rv32i_dec_pkg::t_reg     src2_reg;
    rv32i_dec_pkg::t_funct3  minor_op;
    rv32i_dec_pkg::t_funct7  upper_op;
    rv32i_dec_pkg::t_imm     immediate;
    rv32i_dec_pkg::t_fmt     format_class;
    rv32i_dec_pkg::t_kind    instr_kind;
    logic                    illegal;

    modport source (
        output valid, output major_opcode, output dest_reg, output src1_reg,
        output src2_reg, output minor_op, output upper_op, output immediate,
        output format_class, output instr_kind, output illegal,
        input ready
    );
    modport sink (
        input valid, input major_opcode, input dest_reg, input src1_reg,
        input src2_reg, input minor_op, input upper_op, input immediate,
        input format_class, input instr_kind, input illegal,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/rv32i_instruction_decoder.sv
`default_nettype none

// RV32I decoder: one instruction word in, one decoded result out. Three register
// stages (input capture, format/instruction match, immediate build and output
// register) lie between the input transfer and output valid, and a new word is
// taken every cycle while the output side keeps up. Each stage holds its word
// while the stage after it is full and stalled; ready is a combinational chain
// from the output ready back through the three valid bits. Unsupported words are
// flagged illegal with an instruction code of zero.

module rv32i_instruction_decoder (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    rv32i_dec_in_if.sink           i_instr,
    rv32i_dec_out_if.source        o_dec
);

    function automatic rv32i_dec_pkg::t_fmt fmt_of(
        input rv32i_dec_pkg::t_opcode op,
        input rv32i_dec_pkg::t_funct3 f3,
        input rv32i_dec_pkg::t_funct7 f7
    );
        rv32i_dec_pkg::t_fmt f;
        case (op)
            rv32i_dec_pkg::OP_REG:    f = rv32i_dec_pkg::FMT_R;
            rv32i_dec_pkg::OP_LOAD:   f = rv32i_dec_pkg::FMT_I;
            rv32i_dec_pkg::OP_IMM:    f = rv32i_dec_pkg::FMT_I;
            rv32i_dec_pkg::OP_JALR:   f = rv32i_dec_pkg::FMT_I;
            rv32i_dec_pkg::OP_SYSTEM: f = rv32i_dec_pkg::FMT_I;
            rv32i_dec_pkg::OP_STORE:  f = rv32i_dec_pkg::FMT_S;
            rv32i_dec_pkg::OP_BRANCH: f = rv32i_dec_pkg::FMT_B;
            rv32i_dec_pkg::OP_LUI:    f = rv32i_dec_pkg::FMT_U;
            rv32i_dec_pkg::OP_AUIPC:  f = rv32i_dec_pkg::FMT_U;
            rv32i_dec_pkg::OP_JAL:    f = rv32i_dec_pkg::FMT_J;
            rv32i_dec_pkg::OP_ZERO:   f = (f3 == rv32i_dec_pkg::F3_ADD &&
                                           f7 == rv32i_dec_pkg::F7_BASE) ?
                                          rv32i_dec_pkg::FMT_NOP :
                                          rv32i_dec_pkg::FMT_UNKNOWN;
            default:                  f = rv32i_dec_pkg::FMT_UNKNOWN;
        endcase
        return f;
    endfunction

    // returns {bad, kind}
    function automatic logic [5:0] kind_of(
        input rv32i_dec_pkg::t_opcode op,
        input rv32i_dec_pkg::t_funct3 f3,
        input rv32i_dec_pkg::t_funct7 f7
    );
        logic                bad;
        rv32i_dec_pkg::t_kind k;
        bad = 1'b0;
        k   = rv32i_dec_pkg::K_ADD;
        case (op)
            rv32i_dec_pkg::OP_REG: begin
                case (f3)
                    rv32i_dec_pkg::F3_ADD: begin
                        if (f7 == rv32i_dec_pkg::F7_BASE) k = rv32i_dec_pkg::K_ADD;
                        else if (f7 == rv32i_dec_pkg::F7_ALT) k = rv32i_dec_pkg::K_SUB;
                        else bad = 1'b1;
                    end
                    rv32i_dec_pkg::F3_SLT:  k = rv32i_dec_pkg::K_SLT;
                    rv32i_dec_pkg::F3_SLTU: k = rv32i_dec_pkg::K_SLTU;
                    rv32i_dec_pkg::F3_XOR:  k = rv32i_dec_pkg::K_XOR;
                    rv32i_dec_pkg::F3_OR:   k = rv32i_dec_pkg::K_OR;
                    rv32i_dec_pkg::F3_AND:  k = rv32i_dec_pkg::K_AND;
                    default:                bad = 1'b1;
                endcase
            end
            rv32i_dec_pkg::OP_LOAD: begin
                case (f3)
                    rv32i_dec_pkg::F3_LB:  k = rv32i_dec_pkg::K_LB;
                    rv32i_dec_pkg::F3_LW:  k = rv32i_dec_pkg::K_LW;
                    rv32i_dec_pkg::F3_LBU: k = rv32i_dec_pkg::K_LBU;
                    default:               bad = 1'b1;
                endcase
            end
            rv32i_dec_pkg::OP_IMM: begin
                case (f3)
                    rv32i_dec_pkg::F3_ADD: k = rv32i_dec_pkg::K_ADDI;
                    rv32i_dec_pkg::F3_SLL: k = rv32i_dec_pkg::K_SLLI;
                    rv32i_dec_pkg::F3_SR: begin
                        if (f7 == rv32i_dec_pkg::F7_BASE) k = rv32i_dec_pkg::K_SRLI;
                        else if (f7 == rv32i_dec_pkg::F7_ALT) k = rv32i_dec_pkg::K_SRAI;
                        else bad = 1'b1;
                    end
                    rv32i_dec_pkg::F3_OR:  k = rv32i_dec_pkg::K_ORI;
                    rv32i_dec_pkg::F3_AND: k = rv32i_dec_pkg::K_ANDI;
                    default:               bad = 1'b1;
                endcase
            end
            rv32i_dec_pkg::OP_STORE: begin
                case (f3)
                    rv32i_dec_pkg::F3_SB: k = rv32i_dec_pkg::K_SB;
                    rv32i_dec_pkg::F3_SW: k = rv32i_dec_pkg::K_SW;
                    default:              bad = 1'b1;
                endcase
            end
            rv32i_dec_pkg::OP_BRANCH: begin
                case (f3)
                    rv32i_dec_pkg::F3_BEQ:  k = rv32i_dec_pkg::K_BEQ;
                    rv32i_dec_pkg::F3_BNE:  k = rv32i_dec_pkg::K_BNE;
                    rv32i_dec_pkg::F3_BLT:  k = rv32i_dec_pkg::K_BLT;
                    rv32i_dec_pkg::F3_BGE:  k = rv32i_dec_pkg::K_BGE;
                    rv32i_dec_pkg::F3_BLTU: k = rv32i_dec_pkg::K_BLTU;
                    rv32i_dec_pkg::F3_BGEU: k = rv32i_dec_pkg::K_BGEU;
                    default:                bad = 1'b1;
                endcase
            end
            rv32i_dec_pkg::OP_LUI:    k = rv32i_dec_pkg::K_LUI;
            rv32i_dec_pkg::OP_JAL:    k = rv32i_dec_pkg::K_JAL;
            rv32i_dec_pkg::OP_AUIPC:  k = rv32i_dec_pkg::K_AUIPC;
            rv32i_dec_pkg::OP_JALR:   k = rv32i_dec_pkg::K_JALR;
            rv32i_dec_pkg::OP_SYSTEM: k = rv32i_dec_pkg::K_ECALL;
            default:                  bad = 1'b1;
        endcase
        if (bad) k = rv32i_dec_pkg::K_ADD;
        return {bad, k};
    endfunction

    function automatic rv32i_dec_pkg::t_imm imm_of(
        input rv32i_dec_pkg::t_word w,
        input rv32i_dec_pkg::t_fmt  f
    );
        rv32i_dec_pkg::t_imm v;
        case (f)
            rv32i_dec_pkg::FMT_I: v = {{20{w[31]}}, w[31:20]};
            rv32i_dec_pkg::FMT_S: v = {{20{w[31]}}, w[31:25], w[11:7]};
            rv32i_dec_pkg::FMT_B: v = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            rv32i_dec_pkg::FMT_U: v = {w[31:12], 12'd0};
            rv32i_dec_pkg::FMT_J: v = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:              v = '0;
        endcase
        return v;
    endfunction

    // stage A: captured word
    logic                   r_a_valid;
    rv32i_dec_pkg::t_word   r_a_word;
    // stage B: word with format and match result
    logic                   r_b_valid;
    rv32i_dec_pkg::t_word   r_b_word;
    rv32i_dec_pkg::t_fmt    r_b_fmt;
    rv32i_dec_pkg::t_kind   r_b_kind;
    logic                   r_b_bad;
    // stage C: output register
    logic                   r_c_valid;
    rv32i_dec_pkg::t_word   r_c_word;
    rv32i_dec_pkg::t_imm    r_c_imm;
    rv32i_dec_pkg::t_fmt    r_c_fmt;
    rv32i_dec_pkg::t_kind   r_c_kind;
    logic                   r_c_bad;

    logic                   c_ready;
    logic                   b_ready;
    logic                   a_ready;
    logic [5:0]             a_match;

    assign c_ready = !r_c_valid || o_dec.ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign i_instr.ready = a_ready;

    assign a_match = kind_of(r_a_word[6:0], r_a_word[14:12], r_a_word[31:25]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_instr.valid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_instr.valid) begin
            r_a_word <= i_instr.instr_word;
        end
        if (b_ready && r_a_valid) begin
            r_b_word <= r_a_word;
            r_b_fmt  <= fmt_of(r_a_word[6:0], r_a_word[14:12], r_a_word[31:25]);
            r_b_bad  <= a_match[5];
            r_b_kind <= a_match[4:0];
        end
        if (c_ready && r_b_valid) begin
            r_c_word <= r_b_word;
            r_c_imm  <= imm_of(r_b_word, r_b_fmt);
            r_c_fmt  <= r_b_fmt;
            r_c_kind <= r_b_kind;
            r_c_bad  <= r_b_bad;
        end
    end

    assign o_dec.valid        = r_c_valid;
    assign o_dec.major_opcode = r_c_word[6:0];
    assign o_dec.dest_reg     = r_c_word[11:7];
    assign o_dec.src1_reg     = r_c_word[19:15];
    assign o_dec.src2_reg     = r_c_word[24:20];
    assign o_dec.minor_op     = r_c_word[14:12];
    assign o_dec.upper_op     = r_c_word[31:25];
    assign o_dec.immediate    = r_c_imm;
    assign o_dec.format_class = r_c_fmt;
    assign o_dec.instr_kind   = r_c_kind;
    assign o_dec.illegal      = r_c_bad;

    a_illegal_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.illegal |-> o_dec.instr_kind == rv32i_dec_pkg::K_ADD)
        else $error("illegal result carries nonzero instruction code");

    a_r_imm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.format_class == rv32i_dec_pkg::FMT_R
        |-> o_dec.immediate == '0)
        else $error("R format with nonzero immediate");

    a_nop_illegal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && (o_dec.format_class == rv32i_dec_pkg::FMT_NOP ||
                        o_dec.format_class == rv32i_dec_pkg::FMT_UNKNOWN)
        |-> o_dec.illegal && o_dec.immediate == '0)
        else $error("NOP or unknown format not flagged illegal");

    a_u_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid && o_dec.format_class == rv32i_dec_pkg::FMT_U
        |-> o_dec.immediate[11:0] == 12'd0)
        else $error("U immediate has low bits set");

endmodule

`default_nettype wire

FILE: tb/sv/tb_rv32i_instruction_decoder.sv
module tb_rv32i_instruction_decoder;

    import rv32i_dec_pkg::*;

    typedef struct packed {
        t_opcode major_opcode;
        t_reg    dest_reg;
        t_reg    src1_reg;
        t_reg    src2_reg;
        t_funct3 minor_op;
        t_funct7 upper_op;
        t_imm    immediate;
        t_fmt    format_class;
        t_kind   instr_kind;
        logic    illegal;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rv32i_dec_in_if  in_if ();
    rv32i_dec_out_if out_if ();

    rv32i_instruction_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (in_if),
        .o_dec   (out_if)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_decoded decode_word(t_word w);
        t_decoded d;
        t_funct3  f3;
        t_funct7  f7;
        logic     hit;
        f3 = w[14:12];
        f7 = w[31:25];
        d.major_opcode = w[6:0];
        d.dest_reg     = w[11:7];
        d.src1_reg     = w[19:15];
        d.src2_reg     = w[24:20];
        d.minor_op     = f3;
        d.upper_op     = f7;
        d.instr_kind   = K_ADD;
        hit            = 1'b1;
        case (w[6:0])
            OP_REG: begin
                d.format_class = FMT_R;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_BASE) d.instr_kind = K_ADD;
                        else if (f7 == F7_ALT) d.instr_kind = K_SUB;
                        else hit = 1'b0;
                    end
                    F3_SLT:  d.instr_kind = K_SLT;
                    F3_SLTU: d.instr_kind = K_SLTU;
                    F3_XOR:  d.instr_kind = K_XOR;
                    F3_OR:   d.instr_kind = K_OR;
                    F3_AND:  d.instr_kind = K_AND;
                    default: hit = 1'b0;
                endcase
            end
            OP_LOAD: begin
                d.format_class = FMT_I;
                case (f3)
                    F3_LB:   d.instr_kind = K_LB;
                    F3_LW:   d.instr_kind = K_LW;
                    F3_LBU:  d.instr_kind = K_LBU;
                    default: hit = 1'b0;
                endcase
            end
            OP_IMM: begin
                d.format_class = FMT_I;
                case (f3)
                    F3_ADD: d.instr_kind = K_ADDI;
                    F3_SLL: d.instr_kind = K_SLLI;
                    F3_SR: begin
                        if (f7 == F7_BASE) d.instr_kind = K_SRLI;
                        else if (f7 == F7_ALT) d.instr_kind = K_SRAI;
                        else hit = 1'b0;
                    end
                    F3_OR:   d.instr_kind = K_ORI;
                    F3_AND:  d.instr_kind = K_ANDI;
                    default: hit = 1'b0;
                endcase
            end
            OP_JALR: begin
                d.format_class = FMT_I;
                d.instr_kind   = K_JALR;
            end
            OP_SYSTEM: begin
                d.format_class = FMT_I;
                d.instr_kind   = K_ECALL;
            end
            OP_STORE: begin
                d.format_class = FMT_S;
                case (f3)
                    F3_SB:   d.instr_kind = K_SB;
                    F3_SW:   d.instr_kind = K_SW;
                    default: hit = 1'b0;
                endcase
            end
            OP_BRANCH: begin
                d.format_class = FMT_B;
                case (f3)
                    F3_BEQ:  d.instr_kind = K_BEQ;
                    F3_BNE:  d.instr_kind = K_BNE;
                    F3_BLT:  d.instr_kind = K_BLT;
                    F3_BGE:  d.instr_kind = K_BGE;
                    F3_BLTU: d.instr_kind = K_BLTU;
                    F3_BGEU: d.instr_kind = K_BGEU;
                    default: hit = 1'b0;
                endcase
            end
            OP_LUI: begin
                d.format_class = FMT_U;
                d.instr_kind   = K_LUI;
            end
            OP_AUIPC: begin
                d.format_class = FMT_U;
                d.instr_kind   = K_AUIPC;
            end
            OP_JAL: begin
                d.format_class = FMT_J;
                d.instr_kind   = K_JAL;
            end
            OP_ZERO: begin
                d.format_class = (f3 == F3_ADD && f7 == F7_BASE) ? FMT_NOP : FMT_UNKNOWN;
                hit = 1'b0;
            end
            default: begin
                d.format_class = FMT_UNKNOWN;
                hit = 1'b0;
            end
        endcase
        case (d.format_class)
            FMT_I:   d.immediate = {{20{w[31]}}, w[31:20]};
            FMT_S:   d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B:   d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U:   d.immediate = {w[31:12], 12'd0};
            FMT_J:   d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: d.immediate = '0;
        endcase
        d.illegal = ~hit;
        if (!hit) d.instr_kind = K_ADD;
        return d;
    endfunction

    class decode_scoreboard;
        t_decoded pending[$];
        t_word    pending_words[$];
        int       errors;
        int       checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function void note_word(t_word w);
            pending.push_back(decode_word(w));
            pending_words.push_back(w);
        endfunction

        task report_mismatch(string field, t_word w, logic [31:0] got_v, logic [31:0] want_v);
            errors++;
            $display("decode mismatch, result %0d word %h: %s got %h want %h",
                     checked, w, field, got_v, want_v);
        endtask

        task check_result(t_decoded got);
            t_decoded want;
            t_word    w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transfer", '0, 32'(got.major_opcode), '0);
            end else begin
                want = pending.pop_front();
                w    = pending_words.pop_front();
                if (got.major_opcode !== want.major_opcode)
                    report_mismatch("major_opcode", w,
                                    32'(got.major_opcode), 32'(want.major_opcode));
                if (got.dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", w,
                                    32'(got.dest_reg), 32'(want.dest_reg));
                if (got.src1_reg !== want.src1_reg)
                    report_mismatch("src1_reg", w,
                                    32'(got.src1_reg), 32'(want.src1_reg));
                if (got.src2_reg !== want.src2_reg)
                    report_mismatch("src2_reg", w,
                                    32'(got.src2_reg), 32'(want.src2_reg));
                if (got.minor_op !== want.minor_op)
                    report_mismatch("minor_op", w,
                                    32'(got.minor_op), 32'(want.minor_op));
                if (got.upper_op !== want.upper_op)
                    report_mismatch("upper_op", w,
                                    32'(got.upper_op), 32'(want.upper_op));
                if (got.immediate !== want.immediate)
                    report_mismatch("immediate", w, got.immediate, want.immediate);
                if (got.format_class !== want.format_class)
                    report_mismatch("format_class", w,
                                    32'(got.format_class), 32'(want.format_class));
                if (got.instr_kind !== want.instr_kind)
                    report_mismatch("instr_kind", w,
                                    32'(got.instr_kind), 32'(want.instr_kind));
                if (got.illegal !== want.illegal)
                    report_mismatch("illegal", w,
                                    32'(got.illegal), 32'(want.illegal));
            end
            checked++;
        endtask
    endclass

    decode_scoreboard sb = new();

    int src_gap_max  = 3;
    int sink_gap_max = 3;
    int hold_cycles  = 0;

    function automatic t_word place(t_word base, t_opcode op, t_funct3 f3);
        return {base[31:15], f3, base[11:7], op};
    endfunction

    // random register fields and immediate bits from base; opcode/funct fixed by kind
    function automatic t_word encode_kind(t_kind k, t_word base);
        case (k)
            K_ADD:   return place({F7_BASE, base[24:0]}, OP_REG, F3_ADD);
            K_SUB:   return place({F7_ALT, base[24:0]}, OP_REG, F3_ADD);
            K_SLT:   return place(base, OP_REG, F3_SLT);
            K_SLTU:  return place(base, OP_REG, F3_SLTU);
            K_XOR:   return place(base, OP_REG, F3_XOR);
            K_OR:    return place(base, OP_REG, F3_OR);
            K_AND:   return place(base, OP_REG, F3_AND);
            K_LB:    return place(base, OP_LOAD, F3_LB);
            K_LW:    return place(base, OP_LOAD, F3_LW);
            K_LBU:   return place(base, OP_LOAD, F3_LBU);
            K_ADDI:  return place(base, OP_IMM, F3_ADD);
            K_SLLI:  return place(base, OP_IMM, F3_SLL);
            K_SRLI:  return place({F7_BASE, base[24:0]}, OP_IMM, F3_SR);
            K_SRAI:  return place({F7_ALT, base[24:0]}, OP_IMM, F3_SR);
            K_ORI:   return place(base, OP_IMM, F3_OR);
            K_ANDI:  return place(base, OP_IMM, F3_AND);
            K_SB:    return place(base, OP_STORE, F3_SB);
            K_SW:    return place(base, OP_STORE, F3_SW);
            K_BEQ:   return place(base, OP_BRANCH, F3_BEQ);
            K_BNE:   return place(base, OP_BRANCH, F3_BNE);
            K_BLT:   return place(base, OP_BRANCH, F3_BLT);
            K_BGE:   return place(base, OP_BRANCH, F3_BGE);
            K_BLTU:  return place(base, OP_BRANCH, F3_BLTU);
            K_BGEU:  return place(base, OP_BRANCH, F3_BGEU);
            K_LUI:   return place(base, OP_LUI, base[14:12]);
            K_JAL:   return place(base, OP_JAL, base[14:12]);
            K_AUIPC: return place(base, OP_AUIPC, base[14:12]);
            K_JALR:  return place(base, OP_JALR, base[14:12]);
            default: return place(base, OP_SYSTEM, base[14:12]);
        endcase
    endfunction

    function automatic t_opcode any_known_opcode();
        case ($urandom_range(0, 10))
            0:       return OP_LOAD;
            1:       return OP_IMM;
            2:       return OP_AUIPC;
            3:       return OP_STORE;
            4:       return OP_REG;
            5:       return OP_LUI;
            6:       return OP_BRANCH;
            7:       return OP_JALR;
            8:       return OP_JAL;
            9:       return OP_SYSTEM;
            default: return OP_ZERO;
        endcase
    endfunction

    // mostly well-formed instructions, the rest raw noise or bad funct fields
    function automatic t_word random_word();
        t_word w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1: w[6:0] = any_known_opcode();
            2: begin
                w[6:0] = OP_ZERO;
                if ($urandom_range(0, 1) == 1) begin
                    w[31:25] = F7_BASE;
                    w[14:12] = F3_ADD;
                end
            end
            default: w = encode_kind(t_kind'($urandom_range(0, K_ECALL)), w);
        endcase
        return w;
    endfunction

    task automatic push_word(t_word w);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.instr_word <= w;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
    endtask

    initial begin : result_sink
        int       stall;
        int       hold_left;
        t_decoded got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) begin
                if (hold_cycles > 0) begin
                    hold_left   = hold_cycles;
                    hold_cycles = 0;
                    out_if.ready <= 1'b0;
                    repeat (hold_left) @(posedge i_clk);
                    out_if.ready <= 1'b1;
                end
                @(posedge i_clk);
            end
            got.major_opcode = out_if.major_opcode;
            got.dest_reg     = out_if.dest_reg;
            got.src1_reg     = out_if.src1_reg;
            got.src2_reg     = out_if.src2_reg;
            got.minor_op     = out_if.minor_op;
            got.upper_op     = out_if.upper_op;
            got.immediate    = out_if.immediate;
            got.format_class = out_if.format_class;
            got.instr_kind   = out_if.instr_kind;
            got.illegal      = out_if.illegal;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        t_word directed[$];
        t_word w;
        int    chunk;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.instr_word = '0;
        out_if.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // NOP pattern, all-ones word, opcode zero with funct3 or funct7 set, bad funct7
        directed.push_back(32'h0000_0000);
        directed.push_back(32'hFFFF_FFFF);
        directed.push_back({17'd0, F3_SLL, 5'd0, OP_ZERO});
        directed.push_back({F7_ALT, 18'd0, OP_ZERO});
        w = encode_kind(K_ADD, '1);
        w[31:25] = ~F7_ALT;
        directed.push_back(w);
        w = encode_kind(K_SRLI, '1);
        w[31:25] = ~F7_BASE;
        directed.push_back(w);
        // funct3 values that select no supported instruction
        directed.push_back(place('1, OP_LOAD, F3_SLL));
        directed.push_back(place('1, OP_STORE, F3_SLL));
        directed.push_back(place('1, OP_BRANCH, F3_SLT));
        directed.push_back(place('1, OP_REG, F3_SLL));
        directed.push_back(place('0, OP_IMM, F3_SLT));
        // immediate extremes per format
        directed.push_back(encode_kind(K_ADDI, '1));
        directed.push_back(encode_kind(K_ADDI, 32'h8000_0000));
        directed.push_back(encode_kind(K_LW, 32'h7FFF_FFFF));
        directed.push_back(encode_kind(K_SW, '1));
        directed.push_back(encode_kind(K_SB, 32'h7FFF_FFFF));
        directed.push_back(encode_kind(K_BEQ, 32'h8000_0000));
        directed.push_back(encode_kind(K_BGEU, '1));
        directed.push_back(encode_kind(K_JAL, 32'h8000_0000));
        directed.push_back(encode_kind(K_JAL, 32'h7FFF_FFFF));
        directed.push_back(encode_kind(K_LUI, '1));
        directed.push_back(encode_kind(K_AUIPC, 32'h8000_0000));
        directed.push_back(encode_kind(K_ECALL, '1));
        directed.push_back(encode_kind(K_SUB, '0));
        directed.push_back(encode_kind(K_SRAI, '1));
        foreach (directed[i]) push_word(directed[i]);

        // sender waits for the pipeline to empty
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);

        // long receiver hold with back-to-back input, so the input side stalls
        src_gap_max = 0;
        hold_cycles = 64;
        while (hold_cycles != 0) @(posedge i_clk);
        repeat (24) push_word(random_word());

        for (chunk = 0; chunk < 6; chunk++) begin
            case (chunk)
                0: begin src_gap_max = 0; sink_gap_max = 0; end
                1: begin src_gap_max = 7; sink_gap_max = 0; end
                2: begin src_gap_max = 0; sink_gap_max = 7; end
                3: begin src_gap_max = 7; sink_gap_max = 7; end
                default: begin
                    src_gap_max  = $urandom_range(0, 7);
                    sink_gap_max = $urandom_range(0, 7);
                end
            endcase
            repeat (250) push_word(random_word());
        end

        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rv32i_dec_pkg.sv
hw/rtl/rv32i_dec_if.sv
hw/rtl/rv32i_instruction_decoder.sv
tb/sv/tb_rv32i_instruction_decoder.sv
